// ----- rtl/quadratic_root_bisection_top_macros.svh -----
// Assertion macros for the quadratic root bisection block.
`ifndef QUADRATIC_ROOT_BISECTION_TOP_MACROS_SVH
`define QUADRATIC_ROOT_BISECTION_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define QRB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define QRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/qrb_pkg.sv -----
// Shared types, constants and a helper function for the quadratic root bisection block.
package qrb_pkg;

  localparam int MAX_ITERATIONS      = 20;
  localparam int POSITIVE_SCAN_LIMIT = 20;
  localparam int NEGATIVE_SCAN_LIMIT = 9;

  localparam int COEF_W = 16;
  localparam int X_W    = 26;                 // Q6.20 abscissa
  localparam int FRAC_W = 20;
  localparam int SQ_W   = 30;                 // floor(x*x / 2^20), unsigned
  localparam int MA_W   = SQ_W + 1;           // multiplier operand A, signed
  localparam int MB_W   = X_W;                // multiplier operand B, signed
  localparam int PROD_W = MA_W + MB_W;
  localparam int VAL_W  = 48;                 // f(x) in units of 2^-20
  localparam int TOL_W  = 20;
  localparam int START_W = 6;
  localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);
  localparam int SCAN_MAX = (POSITIVE_SCAN_LIMIT > NEGATIVE_SCAN_LIMIT) ?
                            POSITIVE_SCAN_LIMIT : NEGATIVE_SCAN_LIMIT;
  localparam int K_W    = $clog2(SCAN_MAX + 1);

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(944);
  localparam logic signed [X_W-1:0] ONE_Q20 = X_W'(1 << FRAC_W);

  // Polynomial coefficients of one item.
  typedef struct packed {
    logic signed [COEF_W-1:0] square;
    logic signed [COEF_W-1:0] linear;
    logic signed [COEF_W-1:0] konst;
  } coef_t;

  // Request from the controller to the evaluator.
  typedef struct packed {
    logic                  start;
    logic signed [X_W-1:0] x;
  } eval_req_t;

  typedef enum logic [2:0] {
    EV_IDLE,
    EV_SQ,
    EV_LIN,
    EV_QUAD,
    EV_ACC
  } eval_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_REQ,
    S_SCAN_WAIT,
    S_BIS_INIT,
    S_BIS_CHECK,
    S_BIS_WAIT,
    S_DONE
  } ctl_state_t;

  // True only when one value is strictly negative and the other strictly positive.
  function automatic logic opposite(input logic signed [VAL_W-1:0] p,
                                    input logic signed [VAL_W-1:0] q);
    logic p_neg, p_pos, q_neg, q_pos;
    p_neg = p[VAL_W-1];
    q_neg = q[VAL_W-1];
    p_pos = !p_neg && (p != '0);
    q_pos = !q_neg && (q != '0);
    return (p_neg && q_pos) || (p_pos && q_neg);
  endfunction

endpackage

// ----- rtl/quadratic_root_bisection_top.sv -----
// Each polynomial point takes one request state plus a pass through the evaluator;
// an item evaluates up to 21 scan points plus up to 20 bisection points.
// Throughput: one item at a time; busy falls in the cycle after the done strobe.
// Reset (synchronous, active high) returns to idle and sets tolerance to 944.
// Results appear for one cycle with done; the receiver cannot stall.
module quadratic_root_bisection_top import qrb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  output logic                      done,
  input  logic signed [COEF_W-1:0]  coef_square,
  input  logic signed [COEF_W-1:0]  coef_linear,
  input  logic signed [COEF_W-1:0]  coef_const,
  input  logic                      search_negative,
  output logic signed [X_W-1:0]     root_value,
  output logic signed [START_W-1:0] bracket_start,
  output logic                      found,
  output logic        [ITER_W-1:0]  iterations_used,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic        [TOL_W-1:0]   cfg_data
);

  ctl_state_t state, state_next;

  logic        [TOL_W-1:0]   tolerance;
  coef_t                     coef;
  logic                      neg;
  logic        [K_W-1:0]     k;
  logic        [K_W-1:0]     scan_limit;
  logic signed [VAL_W-1:0]  prev_f;
  logic                      seen;
  logic signed [START_W-1:0] start_pt;
  logic signed [VAL_W-1:0]  low_end_value;
  logic signed [X_W-1:0]    bracket_low;
  logic signed [X_W-1:0]    bracket_high;
  logic signed [X_W-1:0]    previous_midpoint;
  logic        [ITER_W-1:0] iter;

  eval_req_t                req;
  logic                     ev_done;
  logic signed [VAL_W-1:0]  ev_value;

  logic signed [X_W-1:0]     scan_x;
  logic signed [X_W:0]       mid_sum;
  logic signed [X_W-1:0]     mid;
  logic signed [X_W:0]       diff;
  logic        [X_W:0]       abs_diff;
  logic                      tol_met;
  logic                      hit;
  logic                      last_point;
  logic signed [X_W-1:0]     init_low;
  logic signed [START_W-1:0] k_start;

  qrb_eval u_eval (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .coef  (coef),
    .done  (ev_done),
    .value (ev_value)
  );

  assign cfg_ready = 1'b1;

  // Tolerance register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tolerance <= cfg_data;
    end
  end

  // Scan point: +k or -k in Q6.20.
  always_comb begin
    scan_x     = $signed({{(X_W - K_W - FRAC_W){1'b0}}, k, {FRAC_W{1'b0}}});
    scan_limit = neg ? K_W'(NEGATIVE_SCAN_LIMIT) : K_W'(POSITIVE_SCAN_LIMIT);
    if (neg) scan_x = -scan_x;
    // Bracket start that a sign change between k-1 and k would record.
    k_start = START_W'(k - K_W'(1));
    if (neg) k_start = -k_start;
    hit        = (k != '0) && opposite(prev_f, ev_value);
    last_point = (k == scan_limit);
  end

  // Midpoint and its distance from the previous midpoint.
  always_comb begin
    mid_sum  = {bracket_low[X_W-1], bracket_low} + {bracket_high[X_W-1], bracket_high};
    mid      = mid_sum[X_W:1];
    diff     = {previous_midpoint[X_W-1], previous_midpoint} - {mid[X_W-1], mid};
    abs_diff = diff[X_W] ? (X_W+1)'(-diff) : diff;
    tol_met  = (iter != '0) && (abs_diff <= (X_W+1)'(tolerance));
    init_low = {start_pt, {FRAC_W{1'b0}}};
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshake outputs and evaluator requests.
  always_comb begin
    state_next = state;
    req.start  = 1'b0;
    req.x      = scan_x;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) state_next = S_SCAN_REQ;
      end
      S_SCAN_REQ: begin
        req.start  = 1'b1;
        state_next = S_SCAN_WAIT;
      end
      S_SCAN_WAIT: begin
        if (ev_done) begin
          if (!last_point) state_next = S_SCAN_REQ;
          else if (seen || hit) state_next = S_BIS_INIT;
          else state_next = S_DONE;
        end
      end
      S_BIS_INIT: begin
        state_next = S_BIS_CHECK;
      end
      S_BIS_CHECK: begin
        req.x = mid;
        if (tol_met) begin
          state_next = S_DONE;
        end else begin
          req.start  = 1'b1;
          state_next = S_BIS_WAIT;
        end
      end
      S_BIS_WAIT: begin
        req.x = mid;
        if (ev_done) begin
          if (iter == ITER_W'(MAX_ITERATIONS - 1)) state_next = S_DONE;
          else state_next = S_BIS_CHECK;
        end
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Item datapath: scan bookkeeping, bracket updates and result registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          coef.square <= coef_square;
          coef.linear <= coef_linear;
          coef.konst  <= coef_const;
          neg         <= search_negative;
          k           <= '0;
          seen        <= 1'b0;
        end
      end
      S_SCAN_WAIT: begin
        if (ev_done) begin
          prev_f <= ev_value;
          k      <= k + K_W'(1);
          if (hit) begin
            seen          <= 1'b1;
            start_pt      <= k_start;
            low_end_value <= prev_f;
          end
          if (last_point && !(seen || hit)) begin
            root_value      <= '0;
            bracket_start   <= '0;
            found           <= 1'b0;
            iterations_used <= '0;
          end
        end
      end
      S_BIS_INIT: begin
        bracket_low  <= init_low;
        bracket_high <= neg ? init_low - ONE_Q20 : init_low + ONE_Q20;
        iter         <= '0;
      end
      S_BIS_CHECK: begin
        if (tol_met) begin
          root_value      <= previous_midpoint;
          bracket_start   <= start_pt;
          found           <= 1'b1;
          iterations_used <= iter + ITER_W'(1);
        end
      end
      S_BIS_WAIT: begin
        if (ev_done) begin
          if (opposite(low_end_value, ev_value)) begin
            bracket_high <= mid;
          end else begin
            bracket_low   <= mid;
            low_end_value <= ev_value;
          end
          previous_midpoint <= mid;
          iter              <= iter + ITER_W'(1);
          if (iter == ITER_W'(MAX_ITERATIONS - 1)) begin
            root_value      <= mid;
            bracket_start   <= start_pt;
            found           <= 1'b1;
            iterations_used <= ITER_W'(MAX_ITERATIONS);
          end
        end
      end
      default: ;
    endcase
  end

`include "quadratic_root_bisection_top_macros.svh"

  // A finished item always returns the block to idle.
  `QRB_ASSERT_NEXT(a_done_then_idle, done, !busy, "block still busy after done")
  // An accepted item keeps the block busy in the next cycle.
  `QRB_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accept did not start work")
  // A missing bracket reports a zero root and no iterations.
  `QRB_ASSERT_SAME(a_not_found_zero, done && !found,
                   root_value == '0 && iterations_used == '0 && bracket_start == '0,
                   "not-found result carries nonzero fields")
  // A found bracket reports between one and the maximum number of iterations.
  `QRB_ASSERT_SAME(a_found_iters, done && found,
                   iterations_used != '0 && iterations_used <= ITER_W'(MAX_ITERATIONS),
                   "found result has an impossible iteration count")

endmodule

// ----- rtl/qrb_mul.sv -----
// Shared signed multiplier with a registered product.
module qrb_mul import qrb_pkg::*; (
  input  logic                     clk,
  input  logic signed [MA_W-1:0]   a,
  input  logic signed [MB_W-1:0]   b,
  output logic signed [PROD_W-1:0] product
);

  // One product per cycle, registered before use.
  always_ff @(posedge clk) begin
    product <= a * b;
  end

endmodule

// ----- rtl/qrb_eval.sv -----
// Polynomial evaluator: three passes through the shared multiplier per point.
module qrb_eval import qrb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  eval_req_t               req,
  input  coef_t                   coef,
  output logic                    done,
  output logic signed [VAL_W-1:0] value
);

  eval_state_t state, state_next;

  logic signed [X_W-1:0]    x;
  logic        [SQ_W-1:0]   sq;
  logic signed [VAL_W-1:0]  acc;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] product;
  logic signed [VAL_W-1:0]  const_term;

  qrb_mul u_mul (
    .clk     (clk),
    .a       (mul_a),
    .b       (mul_b),
    .product (product)
  );

  // Constant term scaled to units of 2^-20.
  assign const_term = {{(VAL_W - COEF_W - FRAC_W){coef.konst[COEF_W-1]}},
                       coef.konst, {FRAC_W{1'b0}}};

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == EV_ACC);
    end
  end

  // Sequencing and multiplier operand selection.
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      EV_IDLE: begin
        if (req.start) state_next = EV_SQ;
      end
      EV_SQ: begin
        mul_a      = MA_W'(x);
        mul_b      = x;
        state_next = EV_LIN;
      end
      EV_LIN: begin
        mul_a      = MA_W'(x);
        mul_b      = MB_W'(coef.linear);
        state_next = EV_QUAD;
      end
      EV_QUAD: begin
        mul_a      = $signed({1'b0, sq});
        mul_b      = MB_W'(coef.square);
        state_next = EV_ACC;
      end
      EV_ACC: begin
        state_next = EV_IDLE;
      end
      default: state_next = EV_IDLE;
    endcase
  end

  // Datapath registers: point, truncated square, partial sum and result.
  always_ff @(posedge clk) begin
    unique case (state)
      EV_IDLE: begin
        if (req.start) x <= req.x;
      end
      EV_LIN: begin
        sq <= product[FRAC_W +: SQ_W];
      end
      EV_QUAD: begin
        acc <= product[VAL_W-1:0] + const_term;
      end
      EV_ACC: begin
        value <= acc + product[VAL_W-1:0];
      end
      default: ;
    endcase
  end

endmodule
